/* design/ndf_pkg.sv */
// ----------------------------------------------------------------------------
// ndf_pkg
// Shared types, constants and the key normalization function of the node
// batch duplicate filter.
// ----------------------------------------------------------------------------
package ndf_pkg;

   localparam int NDF_TABLE_ENTRIES = 10;
   localparam int NDF_TABLE_MAX     = 64;
   localparam int KEY_W             = 56;
   localparam int BATCH_W           = 16;
   localparam int SLOT_W            = 6;
   localparam int KEY_BYTES         = 7;

   // "UNKNOWN" with the first character in the low byte.
   localparam logic [KEY_W-1:0] KEY_UNKNOWN = 56'h4E_574F_4E4B_4E55;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } ndf_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ndf_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
   } ndf_status_type;

   // The key is a text string: every byte after the first zero byte is
   // cleared, and an empty string becomes UNKNOWN.
   function automatic logic [KEY_W-1:0] ndf_normalize_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] key;
      logic             ended;
      key   = '0;
      ended = 1'b0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (raw[8*b +: 8] == 8'h00) begin
            ended = 1'b1;
         end
         if (!ended) begin
            key[8*b +: 8] = raw[8*b +: 8];
         end
      end
      if (key == '0) begin
         key = KEY_UNKNOWN;
      end
      return key;
   endfunction

endpackage

/* design/ndf_ram.sv */
// ----------------------------------------------------------------------------
// ndf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ndf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ndf_ctrl.sv */
// ----------------------------------------------------------------------------
// ndf_ctrl
// Sequencer of the duplicate filter: accept, table scan, commit and result.
// ----------------------------------------------------------------------------
module ndf_ctrl
   import ndf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  ndf_status_type status,
   output ndf_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid
);

   ndf_state_type state_ff;
   ndf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            rsp_valid  = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/ndf_datapath.sv */
// ----------------------------------------------------------------------------
// ndf_datapath
// Holds the request, scans the key table one entry per cycle and applies the
// table update chosen by the scan.
// ----------------------------------------------------------------------------
module ndf_datapath
   import ndf_pkg::*;
#(
   parameter int TABLE_ENTRIES = NDF_TABLE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  ndf_cmd_type        cmd,
   output ndf_status_type     status,
   input  logic [KEY_W-1:0]   req_node_key,
   input  logic [BATCH_W-1:0] req_batch_number,
   output logic               rsp_is_duplicate,
   output logic               rsp_node_known,
   output logic [SLOT_W-1:0]  rsp_slot
);

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENTRY_W = KEY_W + BATCH_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [KEY_W-1:0]         key_ff;
   logic [BATCH_W-1:0]       batch_ff;
   logic [IDX_W-1:0]         rd_addr_ff;
   logic                     issuing_ff;
   logic                     cmp_en_ff;
   logic [IDX_W-1:0]         cmp_idx_ff;
   logic                     have_free_ff;
   logic [IDX_W-1:0]         free_ff;
   logic                     hit_ff;
   logic                     dup_ff;
   logic [IDX_W-1:0]         slot_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic [ENTRY_W-1:0] rd_entry;
   logic [KEY_W-1:0]   rd_key;
   logic [BATCH_W-1:0] rd_batch;
   logic               match;
   logic               free_now;
   logic               wr_en;

   assign rd_key   = rd_entry[ENTRY_W-1 -: KEY_W];
   assign rd_batch = rd_entry[BATCH_W-1:0];

   // Entry contents are only looked at once the valid bit says they were written.
   assign match    = cmp_en_ff && valid_ff[cmp_idx_ff] && (rd_key == key_ff);
   assign free_now = cmp_en_ff && !valid_ff[cmp_idx_ff];

   assign status.hit  = match;
   assign status.last = cmp_en_ff && (cmp_idx_ff == LAST_IDX);

   assign wr_en = cmd.commit && (!hit_ff || !dup_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff       <= ndf_normalize_key(req_node_key);
         batch_ff     <= req_batch_number;
         rd_addr_ff   <= '0;
         issuing_ff   <= 1'b1;
         cmp_en_ff    <= 1'b0;
         have_free_ff <= 1'b0;
      end else if (cmd.scan) begin
         cmp_en_ff  <= issuing_ff;
         cmp_idx_ff <= rd_addr_ff;
         if (issuing_ff) begin
            if (rd_addr_ff == LAST_IDX) begin
               issuing_ff <= 1'b0;
            end else begin
               rd_addr_ff <= rd_addr_ff + 1'b1;
            end
         end
         if (free_now && !have_free_ff) begin
            have_free_ff <= 1'b1;
            free_ff      <= cmp_idx_ff;
         end
         if (match) begin
            hit_ff  <= 1'b1;
            dup_ff  <= (rd_batch == batch_ff);
            slot_ff <= cmp_idx_ff;
         end else if (status.last) begin
            hit_ff <= 1'b0;
            dup_ff <= 1'b0;
            // A full table overwrites entry zero.
            if (have_free_ff) begin
               slot_ff <= free_ff;
            end else if (free_now) begin
               slot_ff <= cmp_idx_ff;
            end else begin
               slot_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && !hit_ff) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   ndf_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data ({key_ff, batch_ff}),
      .rd_en   (cmd.scan && issuing_ff),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_entry)
   );

   assign rsp_is_duplicate = dup_ff;
   assign rsp_node_known   = hit_ff;
   assign rsp_slot         = SLOT_W'(slot_ff);

endmodule

/* design/node_batch_duplicate_filter.sv */
// ----------------------------------------------------------------------------
// node_batch_duplicate_filter
// Duplicate packet filter keyed by node: remembers the last batch number of
// each node key and flags a repeated batch.
// ----------------------------------------------------------------------------
//  Channel   Ports                                        Transfer
//  request   start, busy, req_node_key, req_batch_number  start high, busy low
//  response  rsp_valid, rsp_is_duplicate, rsp_node_known, rsp_valid high,
//            rsp_slot                                     one cycle
//
//  For each request the table RAM is read one entry per cycle until the key
//  is found or the last entry is compared, then the commit state writes the
//  table and shows the response. Reset clears every valid bit at once, with
//  no clearing pass.
//  The response cannot be stalled; busy stays high until it has been shown.
// ----------------------------------------------------------------------------
module node_batch_duplicate_filter
   import ndf_pkg::*;
#(
   parameter int TABLE_ENTRIES = NDF_TABLE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [KEY_W-1:0]   req_node_key,
   input  logic [BATCH_W-1:0] req_batch_number,
   output logic               rsp_valid,
   output logic               rsp_is_duplicate,
   output logic               rsp_node_known,
   output logic [SLOT_W-1:0]  rsp_slot
);

   ndf_cmd_type    cmd;
   ndf_status_type status;

   ndf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ndf_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_node_key     (req_node_key),
      .req_batch_number (req_batch_number),
      .rsp_is_duplicate (rsp_is_duplicate),
      .rsp_node_known   (rsp_node_known),
      .rsp_slot         (rsp_slot)
   );

endmodule

/* design/ndf_checker.sv */
// ----------------------------------------------------------------------------
// ndf_assertions
// Port-level checks of the duplicate filter's request/response sequencing.
// ----------------------------------------------------------------------------
module ndf_assertions (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_is_duplicate,
   input logic rsp_node_known
);

   // An accepted request keeps the block busy until its response.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // A response only belongs to a request in flight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response shown while idle");

   // Exactly one response per request: the block is free right after it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block not idle after response");

   // A duplicate can only come from a known node.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_duplicate) |-> rsp_node_known)
      else $error("duplicate reported for an unknown node");

endmodule

bind node_batch_duplicate_filter ndf_assertions u_ndf_assertions (.*);

/* bench/ndf_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ndf_checker
// Watches the request and response channels of the duplicate filter. It keeps
// its own copy of the node table, works out the response of every accepted
// request and compares the responses in order, field by field.
// ----------------------------------------------------------------------------
module ndf_checker
   import ndf_pkg::*;
#(
   parameter int TABLE_ENTRIES = NDF_TABLE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [KEY_W-1:0]   req_node_key,
   input  logic [BATCH_W-1:0] req_batch_number,
   input  logic               rsp_valid,
   input  logic               rsp_is_duplicate,
   input  logic               rsp_node_known,
   input  logic [SLOT_W-1:0]  rsp_slot,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic              is_duplicate;
      logic              node_known;
      logic [SLOT_W-1:0] slot;
   } filter_result_type;

   logic               node_valid [TABLE_ENTRIES];
   logic [KEY_W-1:0]   node_key   [TABLE_ENTRIES];
   logic [BATCH_W-1:0] node_batch [TABLE_ENTRIES];
   filter_result_type  expected_responses [$];
   int                 failures = 0;

   // Copies the key bytes up to the first zero byte; an empty text is UNKNOWN.
   function automatic logic [KEY_W-1:0] text_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] key;
      int               n;
      key = '0;
      n   = 0;
      while (n < KEY_BYTES && raw[8*n +: 8] != 8'h00) begin
         key[8*n +: 8] = raw[8*n +: 8];
         n++;
      end
      if (n == 0) begin
         key = KEY_UNKNOWN;
      end
      return key;
   endfunction

   // Looks the node up, updates the table and returns the response it implies.
   function automatic filter_result_type filter_packet(input logic [KEY_W-1:0]   raw,
                                                       input logic [BATCH_W-1:0] batch);
      filter_result_type res;
      logic [KEY_W-1:0]  key;
      int                free_slot;
      key       = text_key(raw);
      free_slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (node_valid[i]) begin
            if (node_key[i] == key) begin
               res.is_duplicate = (node_batch[i] == batch);
               res.node_known   = 1'b1;
               res.slot         = SLOT_W'(i);
               node_batch[i]    = batch;
               return res;
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      // With every entry taken, a new node overwrites entry 0.
      if (free_slot < 0) begin
         free_slot = 0;
      end
      node_valid[free_slot] = 1'b1;
      node_key[free_slot]   = key;
      node_batch[free_slot] = batch;
      res.is_duplicate      = 1'b0;
      res.node_known        = 1'b0;
      res.slot              = SLOT_W'(free_slot);
      return res;
   endfunction

   always @(posedge clock) begin
      filter_result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            node_valid[i] = 1'b0;
         end
         expected_responses.delete();
      end else begin
         // A response always belongs to an earlier transfer, so it is
         // checked before a request accepted at the same edge is queued.
         if (rsp_valid) begin
            if (expected_responses.size() == 0) begin
               $error("response with none expected: slot %0d", rsp_slot);
               failures++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_is_duplicate !== want.is_duplicate) begin
                  $error("is_duplicate: expected %0d, got %0d",
                         want.is_duplicate, rsp_is_duplicate);
                  failures++;
               end
               if (rsp_node_known !== want.node_known) begin
                  $error("node_known: expected %0d, got %0d",
                         want.node_known, rsp_node_known);
                  failures++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            expected_responses.push_back(filter_packet(req_node_key, req_batch_number));
         end
      end
      fail_count    <= failures;
      pending_count <= expected_responses.size();
   end

endmodule

/* bench/node_batch_duplicate_filter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// node_batch_duplicate_filter_tb
// Drives the duplicate filter with a directed sequence covering empty and
// truncated keys, repeats, batch updates and a full table, then with random
// traffic drawn mostly from a small set of node names so that hits, repeats
// and evictions of entry 0 are frequent. Checking is done by ndf_checker.
// ----------------------------------------------------------------------------
module node_batch_duplicate_filter_tb;
   import ndf_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int QUIET_TAIL   = 150;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int POOL_SIZE    = 14;
   localparam int SETTLE       = 20;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [KEY_W-1:0]   req_node_key;
   logic [BATCH_W-1:0] req_batch_number;
   logic               rsp_valid;
   logic               rsp_is_duplicate;
   logic               rsp_node_known;
   logic [SLOT_W-1:0]  rsp_slot;
   int                 fail_count;
   int                 pending_count;
   int                 cycle_count = 0;

   // Node names the random traffic keeps returning to.
   logic [KEY_W-1:0]   pool_key   [POOL_SIZE];
   int                 pool_len   [POOL_SIZE];
   logic [BATCH_W-1:0] pool_batch [POOL_SIZE];

   node_batch_duplicate_filter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_node_key     (req_node_key),
      .req_batch_number (req_batch_number),
      .rsp_valid        (rsp_valid),
      .rsp_is_duplicate (rsp_is_duplicate),
      .rsp_node_known   (rsp_node_known),
      .rsp_slot         (rsp_slot)
   );

   ndf_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_node_key     (req_node_key),
      .req_batch_number (req_batch_number),
      .rsp_valid        (rsp_valid),
      .rsp_is_duplicate (rsp_is_duplicate),
      .rsp_node_known   (rsp_node_known),
      .rsp_slot         (rsp_slot),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Leaves start high after the transfer; the caller either sends the next
   // request or lowers start in the same time step.
   task automatic send_packet(input logic [KEY_W-1:0] key, input logic [BATCH_W-1:0] batch);
      start            <= 1'b1;
      req_node_key     <= key;
      req_batch_number <= batch;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // The pending count is a registered copy, so drain waits on the clock before it reads the count.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_pool_packet(input int idx);
      send_packet(pool_key[idx], pool_batch[idx]);
   endtask

   task automatic send_random_packet();
      int                 pick;
      int                 idx;
      logic [KEY_W-1:0]   raw;
      logic [BATCH_W-1:0] batch;
      pick  = $urandom_range(0, 99);
      batch = 16'($urandom);
      if (pick < 85) begin
         idx = $urandom_range(0, POOL_SIZE - 1);
         raw = pool_key[idx];
         // Bytes after the terminating zero must not change the name.
         if (pool_len[idx] < KEY_BYTES - 1 && $urandom_range(0, 1) == 1) begin
            for (int b = pool_len[idx] + 1; b < KEY_BYTES; b++) begin
               raw[8*b +: 8] = 8'($urandom);
            end
         end
         case ($urandom_range(0, 3))
            0, 1: batch = pool_batch[idx];
            2: batch = pool_batch[idx] + 16'd1;
            default: ;
         endcase
         pool_batch[idx] = batch;
      end else if (pick < 95) begin
         raw = {24'($urandom), 32'($urandom)};
      end else begin
         raw        = {24'($urandom), 32'($urandom)};
         raw[7:0]   = 8'h00;
      end
      send_packet(raw, batch);
   endtask

   initial begin
      int gap_percent;
      reset            = 1'b1;
      start            = 1'b0;
      req_node_key     = '0;
      req_batch_number = '0;
      gap_percent      = 0;

      for (int p = 0; p < 9; p++) begin
         pool_len[p] = $urandom_range(1, KEY_BYTES);
         pool_key[p] = '0;
         for (int b = 0; b < pool_len[p]; b++) begin
            pool_key[p][8*b +: 8] = 8'($urandom_range(1, 255));
         end
      end
      pool_key[9]  = {KEY_W{1'b1}};
      pool_len[9]  = KEY_BYTES;
      pool_key[10] = 56'h0000_0000_0000_4241;
      pool_len[10] = 2;
      pool_key[11] = 56'h0000_0000_0000_0001;
      pool_len[11] = 1;
      pool_key[12] = 56'h0011_2233_4455_66;
      pool_len[12] = 6;
      pool_key[13] = KEY_UNKNOWN;
      pool_len[13] = KEY_BYTES;
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_batch[p] = 16'($urandom);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty key, then the literal name it stands for.
      send_packet('0, 16'h0000);
      send_packet(KEY_UNKNOWN, 16'h0000);
      // All-ones key and batch, a repeat, then a batch update.
      send_packet({KEY_W{1'b1}}, 16'hFFFF);
      hold_off($urandom_range(1, 5));
      send_packet({KEY_W{1'b1}}, 16'hFFFF);
      send_packet({KEY_W{1'b1}}, 16'h0000);
      // Garbage after the terminator, then the same name written cleanly.
      send_packet(56'h5A3C_7E11_0042_41, 16'h8000);
      send_packet(56'h0000_0000_0000_4241, 16'h8000);
      hold_off($urandom_range(1, 5));
      // Empty key with garbage in the upper bytes updates the UNKNOWN entry.
      send_packet(56'hDEAD_BEEF_1234_00, 16'h0001);
      send_packet(56'h0000_0000_0000_0001, 16'h0000);
      send_packet(56'h0011_2233_4455_66, 16'hAAAA);
      send_packet(56'h7F6E_5D4C_3B2A_19, 16'h5555);
      // Fill the rest of the table, then overflow it into entry 0.
      for (int p = 0; p < 4; p++) begin
         send_pool_packet(p);
      end
      hold_off($urandom_range(1, 5));
      send_pool_packet(5);
      send_pool_packet(6);
      send_packet('0, 16'h0000);
      send_packet({KEY_W{1'b1}}, 16'h0000);
      send_pool_packet(0);
      send_packet(56'h7F6E_5D4C_3B2A_19, 16'h5555);
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
            gap_percent = 0;
         end else if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_percent = 0;
               1: gap_percent = 25;
               default: gap_percent = 60;
            endcase
         end
         if (n == 400 || n == 800) begin
            drain();
         end
         send_random_packet();
         if ($urandom_range(0, 99) < gap_percent) begin
            hold_off($urandom_range(1, 5));
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
